// ===== hdl/ordered_piece_list_engine_unit_assert.svh =====
// Assertion macros used by the checker file
`ifndef ORDERED_PIECE_LIST_ENGINE_UNIT_ASSERT_SVH
`define ORDERED_PIECE_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset
`define OPLE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset
`define OPLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ople_pkg.sv =====
package ople_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int OPC_W   = 3;
    localparam int PIECE_W = 4;
    localparam int COLOR_W = 2;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 7;

    localparam int S_FIELDS_W = OPC_W + PIECE_W + POS_W;
    localparam int M_FIELDS_W = STAT_W + CNT_W + PIECE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OPC_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_REMOVE    = 3'd2,
        OP_ROTATE    = 3'd3,
        OP_READ      = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_MISS  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_WB,
        FSM_RDWAIT,
        FSM_RESULT
    } state_t;

endpackage

// ===== hdl/ordered_piece_list_engine_unit.sv =====
// channel | direction | handshake          | payload
// s_      | in        | s_tvalid, s_tready | s_tdata: opcode, piece, position
// m_      | out       | m_tvalid, m_tready | m_tdata: status, entry_count, read_piece
//
// An insert goes from IDLE straight to RESULT, a read passes RDWAIT, a remove SCAN and a
// rotate SCAN and, on a match, WB; remove and rotate walk the stored entries through the single
// read port of the entry memory, one entry a cycle.
// Reset clears state, count, front pointer and the valid flags; the entry memory is not cleared.
// A new item is taken while the previous result waits in the output register;
// a finished result is held inside until that register frees.
module ordered_piece_list_engine_unit #(
    parameter int CAPACITY = ople_pkg::CAPACITY_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [2:0] opcode, [6:3] piece, [12:7] position
    input  logic [ople_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] status, [8:2] entry_count, [12:9] read_piece
    output logic [ople_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > ople_pkg::POS_W) ? CW : ople_pkg::POS_W;
    localparam logic [AW:0]    CAP_EXT   = (AW + 1)'(CAPACITY);
    localparam logic [CW-1:0]  CAP_CNT   = CW'(CAPACITY);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(CAPACITY - 1);

    ople_pkg::state_t                  state_reg, state_next;
    ople_pkg::op_t                     op_reg, op_next;
    logic [ople_pkg::PIECE_W-1:0]      key_reg, key_next;
    logic [AW-1:0]                     front_reg, front_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [CW-1:0]                     idx_reg, idx_next;
    logic                              rvalid_reg, rvalid_next;
    logic                              rlast_reg, rlast_next;
    logic [AW-1:0]                     raddr_reg, raddr_next;
    logic [AW-1:0]                     prev_reg, prev_next;
    logic                              found_reg, found_next;
    logic [ople_pkg::PIECE_W-1:0]      first_reg, first_next;
    ople_pkg::status_t                 res_status_reg, res_status_next;
    logic [ople_pkg::PIECE_W-1:0]      res_piece_reg, res_piece_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    ople_pkg::status_t                 m_status_reg, m_status_next;
    logic [ople_pkg::CNT_W-1:0]        m_count_reg, m_count_next;
    logic [ople_pkg::PIECE_W-1:0]      m_piece_reg, m_piece_next;

    ople_pkg::op_t                     in_op;
    logic [ople_pkg::PIECE_W-1:0]      in_piece;
    logic [ople_pkg::POS_W-1:0]        in_pos;
    logic [CMPW-1:0]                   pos_ext;
    logic [CMPW-1:0]                   cnt_ext;

    logic [CW-1:0]                     slot_idx;
    logic [AW:0]                       slot_sum;
    logic [AW-1:0]                     slot_addr;
    logic [AW-1:0]                     front_dec;
    logic                              out_free;
    logic                              match;

    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr;
    logic [ople_pkg::PIECE_W-1:0]      ram_wdata;
    logic                              ram_re;
    logic [ople_pkg::PIECE_W-1:0]      ram_rdata;

    assign in_op    = ople_pkg::op_t'(s_tdata[ople_pkg::OPC_W-1:0]);
    assign in_piece = s_tdata[ople_pkg::OPC_W +: ople_pkg::PIECE_W];
    assign in_pos   = s_tdata[ople_pkg::OPC_W + ople_pkg::PIECE_W +: ople_pkg::POS_W];
    assign pos_ext  = CMPW'(in_pos);
    assign cnt_ext  = CMPW'(count_reg);

    always_comb begin
        if (state_reg == ople_pkg::FSM_SCAN) begin
            slot_idx = idx_reg;
        end else if (in_op == ople_pkg::OP_READ) begin
            slot_idx = pos_ext[CW-1:0];
        end else begin
            slot_idx = count_reg;
        end
    end

    assign slot_sum  = {1'b0, front_reg} + {1'b0, slot_idx[AW-1:0]};
    assign slot_addr = (slot_sum >= CAP_EXT) ? AW'(slot_sum - CAP_EXT) : slot_sum[AW-1:0];
    assign front_dec = (front_reg == '0) ? LAST_ADDR : front_reg - AW'(1);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign match     = (op_reg == ople_pkg::OP_ROTATE)
                     ? (ram_rdata[ople_pkg::COLOR_W-1:0] == key_reg[ople_pkg::COLOR_W-1:0])
                     : (ram_rdata == key_reg);

    ople_ram #(
        .WIDTH (ople_pkg::PIECE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ople_pkg::FSM_IDLE;
            front_reg    <= '0;
            count_reg    <= '0;
            rvalid_reg   <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            count_reg    <= count_next;
            rvalid_reg   <= rvalid_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        rlast_reg      <= rlast_next;
        raddr_reg      <= raddr_next;
        prev_reg       <= prev_next;
        first_reg      <= first_next;
        res_status_reg <= res_status_next;
        res_piece_reg  <= res_piece_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
        m_piece_reg    <= m_piece_next;
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        rvalid_next     = rvalid_reg;
        rlast_next      = rlast_reg;
        raddr_next      = raddr_reg;
        prev_next       = prev_reg;
        found_next      = found_reg;
        first_next      = first_reg;
        res_status_next = res_status_reg;
        res_piece_next  = res_piece_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;
        m_piece_next    = m_piece_reg;
        ram_we          = 1'b0;
        ram_waddr       = prev_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        s_tready        = (state_reg == ople_pkg::FSM_IDLE);

        case (state_reg)
            ople_pkg::FSM_IDLE: begin
                if (s_tvalid) begin
                    op_next         = in_op;
                    key_next        = in_piece;
                    res_status_next = ople_pkg::STAT_DONE;
                    res_piece_next  = '0;
                    state_next      = ople_pkg::FSM_RESULT;
                    case (in_op)
                        ople_pkg::OP_INS_FRONT: begin
                            if (count_reg == CAP_CNT) begin
                                res_status_next = ople_pkg::STAT_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = front_dec;
                                ram_wdata  = in_piece;
                                front_next = front_dec;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ople_pkg::OP_INS_BACK: begin
                            if (count_reg == CAP_CNT) begin
                                res_status_next = ople_pkg::STAT_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = slot_addr;
                                ram_wdata  = in_piece;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ople_pkg::OP_REMOVE, ople_pkg::OP_ROTATE: begin
                            if (count_reg == '0) begin
                                res_status_next = ople_pkg::STAT_MISS;
                            end else begin
                                idx_next    = '0;
                                rvalid_next = 1'b0;
                                found_next  = 1'b0;
                                state_next  = ople_pkg::FSM_SCAN;
                            end
                        end
                        ople_pkg::OP_READ: begin
                            if (pos_ext < cnt_ext) begin
                                ram_re     = 1'b1;
                                state_next = ople_pkg::FSM_RDWAIT;
                            end else begin
                                res_status_next = ople_pkg::STAT_RANGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ople_pkg::FSM_SCAN: begin
                if (idx_reg < count_reg) begin
                    ram_re      = 1'b1;
                    idx_next    = idx_reg + CW'(1);
                    rvalid_next = 1'b1;
                    raddr_next  = slot_addr;
                    rlast_next  = (idx_reg == count_reg - CW'(1));
                end else begin
                    rvalid_next = 1'b0;
                end

                if (rvalid_reg) begin
                    if (op_reg == ople_pkg::OP_ROTATE) begin
                        if (match) begin
                            if (found_reg) begin
                                ram_we = 1'b1;
                            end else begin
                                first_next = ram_rdata;
                            end
                            found_next = 1'b1;
                            prev_next  = raddr_reg;
                        end
                        if (rlast_reg) begin
                            if (found_reg || match) begin
                                state_next = ople_pkg::FSM_WB;
                            end else begin
                                res_status_next = ople_pkg::STAT_MISS;
                                state_next      = ople_pkg::FSM_RESULT;
                            end
                        end
                    end else begin
                        if (found_reg) begin
                            ram_we    = 1'b1;
                            prev_next = raddr_reg;
                        end else if (match) begin
                            found_next = 1'b1;
                            prev_next  = raddr_reg;
                        end
                        if (rlast_reg) begin
                            if (found_reg || match) begin
                                count_next      = count_reg - CW'(1);
                                res_status_next = ople_pkg::STAT_DONE;
                            end else begin
                                res_status_next = ople_pkg::STAT_MISS;
                            end
                            state_next = ople_pkg::FSM_RESULT;
                        end
                    end
                end
            end

            ople_pkg::FSM_WB: begin
                ram_we          = 1'b1;
                ram_wdata       = first_reg;
                res_status_next = ople_pkg::STAT_DONE;
                state_next      = ople_pkg::FSM_RESULT;
            end

            ople_pkg::FSM_RDWAIT: begin
                res_piece_next = ram_rdata;
                state_next     = ople_pkg::FSM_RESULT;
            end

            ople_pkg::FSM_RESULT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_count_next  = ople_pkg::CNT_W'(count_reg);
                    m_piece_next  = res_piece_reg;
                    state_next    = ople_pkg::FSM_IDLE;
                end
            end

            default: begin
                state_next = ople_pkg::FSM_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = ople_pkg::M_TDATA_W'({m_piece_reg, m_count_reg, m_status_reg});

endmodule

// ===== hdl/ople_ram.sv =====
module ople_ram #(
    parameter int WIDTH = ople_pkg::PIECE_W,
    parameter int DEPTH = ople_pkg::CAPACITY_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ople_chk.sv =====
`include "ordered_piece_list_engine_unit_assert.svh"

module ople_chk #(
    parameter int CAPACITY = ople_pkg::CAPACITY_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [ople_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ople_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam logic [ople_pkg::CNT_W-1:0] CAP_OUT = ople_pkg::CNT_W'(CAPACITY);

    logic                         m_stall;
    logic [ople_pkg::STAT_W-1:0]  m_status;
    logic [ople_pkg::CNT_W-1:0]   m_count;
    logic [ople_pkg::PIECE_W-1:0] m_piece;
    logic                         s_read;

    assign m_stall  = m_tvalid && !m_tready;
    assign m_status = m_tdata[ople_pkg::STAT_W-1:0];
    assign m_count  = m_tdata[ople_pkg::STAT_W +: ople_pkg::CNT_W];
    assign m_piece  = m_tdata[ople_pkg::STAT_W + ople_pkg::CNT_W +: ople_pkg::PIECE_W];
    assign s_read   = s_tvalid && s_tready
                   && (s_tdata[ople_pkg::OPC_W-1:0] == ople_pkg::OP_READ);

    `OPLE_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_stall, m_tvalid, "result dropped while stalled")
    `OPLE_ASSERT_NEXT(a_m_stable, aclk, aresetn, m_stall, $stable(m_tdata), "result changed while stalled")
    `OPLE_ASSERT_NOW(a_full_count, aclk, aresetn, m_tvalid && (m_status == ople_pkg::STAT_FULL), m_count == CAP_OUT, "full rejection below capacity")
    `OPLE_ASSERT_NOW(a_piece_done, aclk, aresetn, m_tvalid && (m_piece != '0), m_status == ople_pkg::STAT_DONE, "read piece on failed operation")
    `OPLE_ASSERT_NEXT(a_read_busy, aclk, aresetn, s_read, !s_tready, "read transfer did not occupy the engine")

endmodule

bind ordered_piece_list_engine_unit ople_chk #(
    .CAPACITY (CAPACITY)
) u_ople_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/tb_ordered_piece_list_engine_unit.sv =====
module tb_ordered_piece_list_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS    = 2000;
    localparam int QUIET_FROM     = 1700;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 100;

    localparam logic [ople_pkg::OPC_W-1:0] FIRST_UNUSED_OP = 3'd5;
    localparam logic [ople_pkg::OPC_W-1:0] MID_UNUSED_OP   = 3'd6;
    localparam logic [ople_pkg::OPC_W-1:0] LAST_UNUSED_OP  = 3'd7;

    typedef struct packed {
        ople_pkg::status_t            status;
        logic [ople_pkg::CNT_W-1:0]   count;
        logic [ople_pkg::PIECE_W-1:0] piece;
    } outcome_t;

    class piece_list_book;
        logic [ople_pkg::PIECE_W-1:0] held_pieces[$];
        outcome_t                     due_outcomes[$];
        int                           mismatches;
        int                           full_rejects;
        int                           misses;
        int                           range_reads;
        int                           peak_fill;

        function int held();
            return held_pieces.size();
        endfunction

        function logic [ople_pkg::PIECE_W-1:0] piece_at(int idx);
            return held_pieces[idx];
        endfunction

        function int outstanding();
            return due_outcomes.size();
        endfunction

        function void note_item(logic [ople_pkg::S_TDATA_W-1:0] data);
            logic [ople_pkg::OPC_W-1:0]   op;
            logic [ople_pkg::PIECE_W-1:0] pc;
            logic [ople_pkg::PIECE_W-1:0] first;
            logic [ople_pkg::POS_W-1:0]   ps;
            int                           hits[$];
            int                           at;
            outcome_t                     o;
            op = data[ople_pkg::OPC_W-1:0];
            pc = data[ople_pkg::OPC_W +: ople_pkg::PIECE_W];
            ps = data[ople_pkg::OPC_W+ople_pkg::PIECE_W +: ople_pkg::POS_W];
            o.status = ople_pkg::STAT_DONE;
            o.count  = '0;
            o.piece  = '0;
            case (op)
                ople_pkg::OP_INS_FRONT, ople_pkg::OP_INS_BACK: begin
                    if (held_pieces.size() >= ople_pkg::CAPACITY_DEF) begin
                        o.status = ople_pkg::STAT_FULL;
                    end else if (op == ople_pkg::OP_INS_FRONT) begin
                        held_pieces.push_front(pc);
                    end else begin
                        held_pieces.push_back(pc);
                    end
                end
                ople_pkg::OP_REMOVE: begin
                    at = -1;
                    foreach (held_pieces[i])
                        if (at < 0 && held_pieces[i] == pc)
                            at = i;
                    if (at < 0)
                        o.status = ople_pkg::STAT_MISS;
                    else
                        held_pieces.delete(at);
                end
                ople_pkg::OP_ROTATE: begin
                    foreach (held_pieces[i])
                        if (held_pieces[i][ople_pkg::COLOR_W-1:0] ==
                            pc[ople_pkg::COLOR_W-1:0])
                            hits.push_back(i);
                    if (hits.size() == 0) begin
                        o.status = ople_pkg::STAT_MISS;
                    end else begin
                        first = held_pieces[hits[0]];
                        for (int k = 0; k + 1 < hits.size(); k++)
                            held_pieces[hits[k]] = held_pieces[hits[k+1]];
                        held_pieces[hits[hits.size()-1]] = first;
                    end
                end
                ople_pkg::OP_READ: begin
                    if (ps < held_pieces.size())
                        o.piece = held_pieces[ps];
                    else
                        o.status = ople_pkg::STAT_RANGE;
                end
                default: ;
            endcase
            o.count = ople_pkg::CNT_W'(held_pieces.size());
            case (o.status)
                ople_pkg::STAT_FULL:  full_rejects++;
                ople_pkg::STAT_MISS:  misses++;
                ople_pkg::STAT_RANGE: range_reads++;
                default: ;
            endcase
            if (held_pieces.size() > peak_fill)
                peak_fill = held_pieces.size();
            due_outcomes.push_back(o);
        endfunction

        function void check_result(logic [ople_pkg::M_TDATA_W-1:0] data);
            outcome_t                     want;
            logic [ople_pkg::STAT_W-1:0]  act_status;
            logic [ople_pkg::CNT_W-1:0]   act_count;
            logic [ople_pkg::PIECE_W-1:0] act_piece;
            act_status = data[ople_pkg::STAT_W-1:0];
            act_count  = data[ople_pkg::STAT_W +: ople_pkg::CNT_W];
            act_piece  = data[ople_pkg::STAT_W+ople_pkg::CNT_W +: ople_pkg::PIECE_W];
            if (due_outcomes.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result %0h with nothing outstanding", data);
                mismatches++;
                return;
            end
            want = due_outcomes.pop_front();
            if (act_status != want.status || act_count != want.count ||
                act_piece != want.piece) begin
                if (mismatches < 10)
                    $display("mismatch (exp/act): status %0d/%0d count %0d/%0d piece %0h/%0h",
                             want.status, act_status, want.count, act_count,
                             want.piece, act_piece);
                mismatches++;
            end
        endfunction
    endclass

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [ople_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [ople_pkg::M_TDATA_W-1:0] m_tdata;

    logic                           idle_on  = 1'b1;
    logic                           hold_req = 1'b0;
    int                             items_sent;
    int                             items_taken;
    int                             results_seen;
    int                             quiet_cycles;
    piece_list_book                 book;

    ordered_piece_list_engine_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                book.note_item(s_tdata);
                items_taken++;
            end
            if (m_tvalid && m_tready) begin
                book.check_result(m_tdata);
                results_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    task automatic offer_item(input logic [ople_pkg::OPC_W-1:0]   op,
                              input logic [ople_pkg::PIECE_W-1:0] piece,
                              input logic [ople_pkg::POS_W-1:0]   pos);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tdata  <= ople_pkg::S_TDATA_W'({pos, piece, op});
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic drain_pause();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (book.outstanding() != 0) @(posedge aclk);
    endtask

    // steer the fill level towards target; removes mostly hit a held piece
    task automatic random_item(input int target);
        int                           cnt;
        int                           r;
        logic [ople_pkg::OPC_W-1:0]   op;
        logic [ople_pkg::PIECE_W-1:0] pc;
        logic [ople_pkg::POS_W-1:0]   ps;
        cnt = book.held();
        r   = $urandom_range(0, 99);
        pc  = ople_pkg::PIECE_W'($urandom);
        ps  = ople_pkg::POS_W'($urandom);
        if (r < 50) begin
            if (cnt < target || (target == ople_pkg::CAPACITY_DEF && r < 20)) begin
                op = $urandom_range(0, 1) ? ople_pkg::OP_INS_BACK : ople_pkg::OP_INS_FRONT;
            end else begin
                op = ople_pkg::OP_REMOVE;
                if (cnt > 0)
                    pc = book.piece_at($urandom_range(0, cnt - 1));
            end
        end else if (r < 58) begin
            op = ople_pkg::OP_REMOVE;
        end else if (r < 72) begin
            op = ople_pkg::OP_ROTATE;
        end else if (r < 94) begin
            op = ople_pkg::OP_READ;
            if (cnt > 0 && r < 88)
                ps = ople_pkg::POS_W'($urandom_range(0, cnt - 1));
        end else begin
            op = ople_pkg::OPC_W'($urandom_range(FIRST_UNUSED_OP, LAST_UNUSED_OP));
        end
        offer_item(op, pc, ps);
    endtask

    initial begin
        int target;
        int round_len;
        int round_no;
        book = new;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer_item(ople_pkg::OP_READ,      4'h0, 6'd0);
        offer_item(ople_pkg::OP_REMOVE,    4'hF, 6'd0);
        offer_item(ople_pkg::OP_ROTATE,    4'h3, 6'd0);
        offer_item(FIRST_UNUSED_OP,        4'h0, 6'd0);
        offer_item(MID_UNUSED_OP,          4'h5, 6'd42);
        offer_item(LAST_UNUSED_OP,         4'hF, 6'd63);
        offer_item(ople_pkg::OP_INS_BACK,  4'hF, 6'd0);
        offer_item(ople_pkg::OP_ROTATE,    4'h3, 6'd0);
        offer_item(ople_pkg::OP_INS_FRONT, 4'h0, 6'd0);
        offer_item(ople_pkg::OP_INS_BACK,  4'h5, 6'd0);
        offer_item(ople_pkg::OP_INS_FRONT, 4'h9, 6'd0);
        offer_item(ople_pkg::OP_INS_BACK,  4'hD, 6'd0);
        offer_item(ople_pkg::OP_ROTATE,    4'h1, 6'd0);
        offer_item(ople_pkg::OP_READ,      4'h0, 6'd0);
        offer_item(ople_pkg::OP_READ,      4'h0, 6'd4);
        offer_item(ople_pkg::OP_READ,      4'h0, 6'd5);
        offer_item(ople_pkg::OP_READ,      4'hF, 6'd63);
        offer_item(ople_pkg::OP_REMOVE,    4'h5, 6'd0);
        offer_item(ople_pkg::OP_REMOVE,    4'h7, 6'd0);
        offer_item(ople_pkg::OP_ROTATE,    4'h2, 6'd0);
        offer_item(ople_pkg::OP_INS_FRONT, 4'hF, 6'd0);
        offer_item(ople_pkg::OP_REMOVE,    4'hF, 6'd0);
        offer_item(ople_pkg::OP_READ,      4'h0, 6'd0);

        round_no = 0;
        while (items_sent < TOTAL_ITEMS) begin
            if (round_no == 0) begin
                target    = ople_pkg::CAPACITY_DEF;
                round_len = 200;
            end else if (round_no == 1) begin
                target    = 0;
                round_len = 200;
            end else begin
                case ($urandom_range(0, 3))
                    0:       target = ople_pkg::CAPACITY_DEF;
                    1:       target = $urandom_range(0, 3);
                    default: target = $urandom_range(0, ople_pkg::CAPACITY_DEF);
                endcase
                round_len = $urandom_range(60, 160);
            end
            repeat (round_len) begin
                if (items_sent >= TOTAL_ITEMS)
                    break;
                if (items_sent == 400 || items_sent == 1300)
                    drain_pause();
                if (items_sent == 700)
                    hold_req = 1'b1;
                if (items_sent == QUIET_FROM)
                    idle_on = 1'b0;
                random_item(target);
            end
            round_no++;
        end

        s_tvalid <= 1'b0;
        while (book.outstanding() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d transfers in, %0d results out over %0d fill rounds, peak %0d",
                 items_taken, results_seen, round_no, book.peak_fill);
        $display("Rejected when full %0d, remove/rotate misses %0d, reads past end %0d",
                 book.full_rejects, book.misses, book.range_reads);
        if (book.mismatches == 0 && book.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== ordered_piece_list_engine_unit.f =====
+incdir+hdl
hdl/ople_pkg.sv
hdl/ople_ram.sv
hdl/ordered_piece_list_engine_unit.sv
hdl/ople_chk.sv
sim/tb_ordered_piece_list_engine_unit.sv
